### hdl/mmad_pkg.sv
// ---------------------------------------------------------------------------
// mmad_pkg: shared types and constants
// Field widths, configuration register codes, reset values, the sequencer
// state type and the widths of the shared serial divider.
// ---------------------------------------------------------------------------
`default_nettype none

package mmad_pkg;

  // channels and field widths
  localparam int NCHAN  = 3;
  localparam int CH_W   = 2;
  localparam int SMP_W  = 16;
  localparam int MAP_W  = 18;
  localparam int FS_W   = 16;
  localparam int DB_W   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [CH_W-1:0] CH_NONE = 2'd3;

  // mapped value limits
  localparam logic [MAP_W-1:0] MAP_POS_SAT = 18'h1FFFF;
  localparam logic [MAP_W-1:0] MAP_NEG_SAT = 18'h20000;
  localparam logic [31:0]      MAP_NEG_MAG = 32'd131072;

  // shared divider widths: unsigned magnitudes
  localparam int DIV_NUM_W = 32;
  localparam int DIV_DEN_W = 16;

  // configuration register codes
  localparam logic [CFG_IDX_W-1:0] CFG_THR_LO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_HI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIX_LO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIX_HI = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRM_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TRM_HI = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FS     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DB     = 3'd7;

  // configuration reset values
  localparam logic [SMP_W-1:0] RST_THR_LO = 16'hFFD8;  // -40
  localparam logic [SMP_W-1:0] RST_THR_HI = 16'd24300;
  localparam logic [SMP_W-1:0] RST_MIX_LO = 16'hFFD8;  // -40
  localparam logic [SMP_W-1:0] RST_MIX_HI = 16'd24300;
  localparam logic [SMP_W-1:0] RST_TRM_LO = 16'd3790;
  localparam logic [SMP_W-1:0] RST_TRM_HI = 16'd18880;
  localparam logic [FS_W-1:0]  RST_FS     = 16'd8192;
  localparam logic [DB_W-1:0]  RST_DB     = 8'd2;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_DIV1_START,
    S_DIV1_WAIT,
    S_SUM,
    S_DIV2_START,
    S_DIV2_WAIT,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

### hdl/mmad_div.sv
// ---------------------------------------------------------------------------
// mmad_div: shared serial divider
// Unsigned restoring division, one quotient bit per cycle. A start pulse
// loads the operands; done pulses in the cycle after the last step, and the
// quotient holds until the next start.
// ---------------------------------------------------------------------------
`default_nettype none

module mmad_div
  import mmad_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [DIV_NUM_W-1:0] num,
  input  wire logic [DIV_DEN_W-1:0] den,
  output logic                      done,
  output logic [DIV_NUM_W-1:0]      quo
);

  localparam int STEP_W = $clog2(DIV_NUM_W + 1);

  logic                 busy_r;
  logic                 done_r;
  logic [STEP_W-1:0]    step_r;
  logic [DIV_NUM_W-1:0] quo_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] den_r;

  logic [DIV_DEN_W:0]   shifted;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  // trial subtract of the divisor from the shifted remainder
  assign shifted = {rem_r, quo_r[DIV_NUM_W-1]};
  assign trial   = shifted - {1'b0, den_r};
  assign fits    = (shifted >= {1'b0, den_r});

  // control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(DIV_NUM_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: shift in numerator bits, shift out quotient bits
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= fits ? trial[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
      quo_r <= {quo_r[DIV_NUM_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

### hdl/mapped_moving_average_deadband.sv
// ---------------------------------------------------------------------------
// mapped_moving_average_deadband: three-channel mapped running average
// Maps each sample through its channel's calibration points, keeps a
// per-channel running average over the last WINDOW mapped values and flags
// averages that leave the dead band around the last reported value.
//
//   port group   dir  tdata (low bit up)            tuser
//   in_          in   sample[15:0]                  channel[1:0]
//   out_         out  average[17:0], report, pad    channel_out[1:0]
//   cfg_         in   wr_en, index[2:0], data[15:0] -
//
// An item passes through the states S_MUL, S_DIV1_START, S_DIV1_WAIT, S_SUM,
// S_DIV2_START, S_DIV2_WAIT and S_DONE between one accepted word and the next;
// each of the two serial divider passes (mapping quotient, then average) holds
// the sequencer until the divider's done pulse. in_tready is high only while the
// sequencer is idle; a result waits in the output register and the next word
// is taken meanwhile, but the sequencer holds in its last state while that
// register is still full. Channel code three is taken and dropped in its
// accept cycle. Reset is synchronous and needs no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module mapped_moving_average_deadband
  import mmad_pkg::*;
#(
  parameter int WINDOW = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input stream
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [15:0]          in_tdata,   // sample[15:0]
  input  wire logic [CH_W-1:0]      in_tuser,   // channel[1:0]
  // result stream
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [23:0]               out_tdata,  // average[17:0], report[18], zero
  output logic [CH_W-1:0]           out_tuser,  // channel_out[1:0]
  // configuration writes
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int SUM_W  = MAP_W + $clog2(WINDOW);
  localparam int NUM2_W = SUM_W + 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int DEPTH  = NCHAN * WINDOW;
  localparam int RA_W   = $clog2(DEPTH);

  // configuration registers
  logic [SMP_W-1:0] lo_r [NCHAN];
  logic [SMP_W-1:0] hi_r [NCHAN];
  logic [FS_W-1:0]  fs_r;
  logic [DB_W-1:0]  db_r;

  // per-channel window state
  logic signed [SUM_W-1:0] sum_r  [NCHAN];
  logic [CNT_W-1:0]        cnt_r  [NCHAN];
  logic [POS_W-1:0]        pos_r  [NCHAN];
  logic [MAP_W-1:0]        last_r [NCHAN];

  // sample ring memory
  logic [MAP_W-1:0] ring [DEPTH];
  logic [MAP_W-1:0] ring_q_r;
  logic [RA_W-1:0]  ring_addr;

  // sequencer and item registers
  state_t           state_r, state_nxt;
  logic [CH_W-1:0]  ch_r;
  logic [SMP_W-1:0] smp_r;
  logic [31:0]      prod_mag_r;
  logic [15:0]      span_mag_r;
  logic             q_neg_r;
  logic             span_zero_r;
  logic             avg_neg_r;

  // output register
  logic             out_valid_r;
  logic [MAP_W-1:0] out_avg_r;
  logic             out_rep_r;
  logic [CH_W-1:0]  out_ch_r;

  // divider hookup
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quo;

  // combinational datapath
  logic signed [16:0]       diff_c;
  logic signed [16:0]       span_c;
  logic signed [16:0]       fs_c;
  logic signed [33:0]       prod_c;
  logic [33:0]              prod_abs_c;
  logic [16:0]              span_abs_c;
  logic [MAP_W-1:0]         mapped_c;
  logic signed [SUM_W-1:0]  mapped_ext_c;
  logic signed [SUM_W-1:0]  old_ext_c;
  logic signed [SUM_W-1:0]  sum_new_c;
  logic                     filling_c;
  logic signed [NUM2_W-1:0] num2_c;
  logic [NUM2_W-1:0]        num2_abs_c;
  logic [MAP_W-1:0]         avg_c;
  logic signed [19:0]       avg20_c;
  logic signed [19:0]       last20_c;
  logic signed [19:0]       band_lo_c;
  logic signed [19:0]       band_hi_c;
  logic                     rep_c;
  logic                     out_free;

  mmad_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // map: signed difference, span and product
  assign diff_c     = $signed({smp_r[SMP_W-1], smp_r})
                    - $signed({lo_r[ch_r][SMP_W-1], lo_r[ch_r]});
  assign span_c     = $signed({hi_r[ch_r][SMP_W-1], hi_r[ch_r]})
                    - $signed({lo_r[ch_r][SMP_W-1], lo_r[ch_r]});
  assign fs_c       = $signed({1'b0, fs_r});
  assign prod_c     = diff_c * fs_c;
  assign prod_abs_c = prod_c[33] ? (34'd0 - prod_c) : prod_c;
  assign span_abs_c = span_c[16] ? (17'd0 - span_c) : span_c;

  // map: sign and saturate the first quotient
  always_comb begin
    if (span_zero_r) begin
      mapped_c = '0;
    end else if (!q_neg_r) begin
      mapped_c = (|div_quo[31:17]) ? MAP_POS_SAT : div_quo[MAP_W-1:0];
    end else if (div_quo > MAP_NEG_MAG) begin
      mapped_c = MAP_NEG_SAT;
    end else begin
      mapped_c = {MAP_W{1'b0}} - div_quo[MAP_W-1:0];
    end
  end

  // window: running sum update
  assign ring_addr    = RA_W'(ch_r * WINDOW) + RA_W'(pos_r[ch_r]);
  assign filling_c    = (cnt_r[ch_r] < CNT_W'(WINDOW));
  assign mapped_ext_c = SUM_W'($signed(mapped_c));
  assign old_ext_c    = SUM_W'($signed(ring_q_r));
  assign sum_new_c    = filling_c ? (sum_r[ch_r] + mapped_ext_c)
                                  : (sum_r[ch_r] + mapped_ext_c - old_ext_c);

  // average: rounded numerator
  assign num2_c     = NUM2_W'(sum_r[ch_r]) + $signed(NUM2_W'(cnt_r[ch_r] >> 1));
  assign num2_abs_c = num2_c[NUM2_W-1] ? ({NUM2_W{1'b0}} - num2_c) : num2_c;

  // average: sign and dead-band test
  assign avg_c     = avg_neg_r ? ({MAP_W{1'b0}} - div_quo[MAP_W-1:0]) : div_quo[MAP_W-1:0];
  assign avg20_c   = 20'($signed(avg_c));
  assign last20_c  = 20'($signed(last_r[ch_r]));
  assign band_lo_c = avg20_c - $signed({12'd0, db_r});
  assign band_hi_c = avg20_c + $signed({12'd0, db_r});
  assign rep_c     = (last20_c < band_lo_c) || (last20_c > band_hi_c);

  assign out_free = !out_valid_r || out_tready;

  // sequencer: next state and divider start
  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    div_num   = prod_mag_r;
    div_den   = span_mag_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tuser != CH_NONE) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_DIV1_START;
      end
      S_DIV1_START: begin
        div_start = 1'b1;
        state_nxt = S_DIV1_WAIT;
      end
      S_DIV1_WAIT: begin
        if (div_done) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        state_nxt = S_DIV2_START;
      end
      S_DIV2_START: begin
        div_start = 1'b1;
        div_num   = DIV_NUM_W'(num2_abs_c);
        div_den   = DIV_DEN_W'(cnt_r[ch_r]);
        state_nxt = S_DIV2_WAIT;
      end
      S_DIV2_WAIT: begin
        if (div_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // hold the sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // capture the accepted word and the mapping operands
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      ch_r  <= in_tuser;
      smp_r <= in_tdata;
    end
    if (state_r == S_MUL) begin
      prod_mag_r  <= prod_abs_c[31:0];
      span_mag_r  <= span_abs_c[15:0];
      q_neg_r     <= prod_c[33] ^ span_c[16];
      span_zero_r <= (span_c == 17'sd0);
    end
    if (state_r == S_DIV2_START) begin
      avg_neg_r <= num2_c[NUM2_W-1];
    end
  end

  // ring memory: read the outgoing entry, write the new one
  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      ring_q_r <= ring[ring_addr];
    end
    if (state_r == S_SUM) begin
      ring[ring_addr] <= mapped_c;
    end
  end

  // configuration writes and per-channel window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r[0] <= RST_THR_LO;
      hi_r[0] <= RST_THR_HI;
      lo_r[1] <= RST_MIX_LO;
      hi_r[1] <= RST_MIX_HI;
      lo_r[2] <= RST_TRM_LO;
      hi_r[2] <= RST_TRM_HI;
      fs_r    <= RST_FS;
      db_r    <= RST_DB;
      for (int i = 0; i < NCHAN; i++) begin
        sum_r[i]  <= '0;
        cnt_r[i]  <= '0;
        pos_r[i]  <= '0;
        last_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_THR_LO: lo_r[0] <= cfg_data;
          CFG_THR_HI: hi_r[0] <= cfg_data;
          CFG_MIX_LO: lo_r[1] <= cfg_data;
          CFG_MIX_HI: hi_r[1] <= cfg_data;
          CFG_TRM_LO: lo_r[2] <= cfg_data;
          CFG_TRM_HI: hi_r[2] <= cfg_data;
          CFG_FS:     fs_r    <= cfg_data;
          CFG_DB:     db_r    <= cfg_data[DB_W-1:0];
          default:    ;
        endcase
      end
      // advance the window
      if (state_r == S_SUM) begin
        sum_r[ch_r] <= sum_new_c;
        if (filling_c) begin
          cnt_r[ch_r] <= cnt_r[ch_r] + 1'b1;
        end
        if (pos_r[ch_r] == POS_W'(WINDOW - 1)) begin
          pos_r[ch_r] <= '0;
        end else begin
          pos_r[ch_r] <= pos_r[ch_r] + 1'b1;
        end
      end
      // replace the last reported value
      if (state_r == S_DONE && out_free && rep_c) begin
        last_r[ch_r] <= avg_c;
      end
    end
  end

  // output register: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register: payload
  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_avg_r <= avg_c;
      out_rep_r <= rep_c;
      out_ch_r  <= ch_r;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_rep_r, out_avg_r};
  assign out_tuser  = out_ch_r;

endmodule

`default_nettype wire
